### hdl/ultrasonic_echo_ranging_defines.svh
// Assertion macros shared by the ultrasonic echo ranging RTL.
`ifndef ULTRASONIC_ECHO_RANGING_DEFINES_SVH
`define ULTRASONIC_ECHO_RANGING_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define UER_ASSERT_NOW(lbl, clk, rst, cond, conseq) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error("ultrasonic echo ranging: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define UER_ASSERT_NEXT(lbl, clk, rst, cond, conseq) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error("ultrasonic echo ranging: next-cycle check failed");

`endif

### hdl/uer_pkg.sv
// Types and constants of the ultrasonic echo ranging block.
package uer_pkg;

   // Field and register widths.
   localparam int TRIG_W      = 8;
   localparam int TIMER_W     = 16;
   localparam int ECHO_W      = 16;
   localparam int SUM_W       = 19;
   localparam int DIST_W      = 15;
   localparam int DIST_FRAC_W = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   // Centimetres per microsecond of round trip, inverted: 58 us per cm.
   localparam int CM_DIVISOR  = 58;

   // Reciprocal divide: quotient = (x * RECIP) >> RECIP_SHIFT, exact for
   // dividends below 2^23 and divisors below 2^9.
   localparam int RECIP_SHIFT = 32;
   localparam int RECIP_W     = 27;

   // Register reset values.
   localparam logic [TRIG_W-1:0]  TRIG_WIDTH_RST = 8'd20;
   localparam logic [TIMER_W-1:0] SETTLE_GAP_RST = 16'd50000;
   localparam logic [ECHO_W-1:0]  MAX_ECHO_RST   = 16'd65535;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TRIGGER_WIDTH = 2'd0,
      CSR_SETTLE_GAP    = 2'd1,
      CSR_MAX_ECHO      = 2'd2
   } csr_index_type;

   // Measurement sequencer phases.
   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_TRIG   = 3'd1,
      PH_WAIT   = 3'd2,
      PH_MEAS   = 3'd3,
      PH_SETTLE = 3'd4
   } phase_type;

   // Status flags that travel down the result pipeline.
   typedef struct packed {
      logic trigger_level;
      logic busy_res;
      logic result_valid;
   } flags_type;

endpackage

### hdl/uer_req_if.sv
// Handshake interfaces of the ultrasonic echo ranging block.
interface uer_req_if;
   logic valid;
   logic ready;
   logic echo_level;
   logic start_request;

   modport source (output valid, echo_level, start_request, input ready);
   modport sink   (input valid, echo_level, start_request, output ready);
endinterface

interface uer_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          trigger_level;
   logic                          busy_res;
   logic                          result_valid;
   logic [uer_pkg::DIST_W-1:0]    distance_q4;

   modport source (output valid, trigger_level, busy_res, result_valid, distance_q4,
                   input ready);
   modport sink   (input valid, trigger_level, busy_res, result_valid, distance_q4,
                   output ready);
endinterface

interface uer_csr_if;
   logic                              valid;
   logic                              ready;
   logic [uer_pkg::CSR_INDEX_W-1:0]   index;
   logic [uer_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### hdl/ultrasonic_echo_ranging.sv
// Ultrasonic echo ranging controller, one input item per microsecond tick.
//
// req_ch carries one tick: the sampled echo pin level and a start request.
// Every accepted tick produces exactly one transfer on rsp_ch with the
// trigger pin level, the busy flag, a one-tick result strobe and the held
// averaged distance in centimetres with four fraction bits.
// csr_ch writes trigger width, settle gap and echo limit and is always ready;
// write it only while no sequence runs; the block itself does not enforce this.
// The sequencer state updates in the cycle a tick is accepted. The result
// travels through three registers (status, reciprocal product, output), and
// one tick is accepted every cycle while the receiver takes results; the rate
// is set by the sequencer update and the one 23x27 multiplier stage.
// Each pipeline stage has its own ready, so a stalled receiver holds only the
// output register, and ticks keep entering until the bubbles ahead are used.
// Reset returns the sequencer to idle, clears the distance to zero, loads the
// register defaults and empties the pipeline.
module ultrasonic_echo_ranging #(
   parameter int NUM_SAMPLES = 5
) (
   input  logic     clock,
   input  logic     reset,
   uer_req_if.sink  req_ch,
   uer_rsp_if.source rsp_ch,
   uer_csr_if.sink  csr_ch
);

`include "ultrasonic_echo_ranging_defines.svh"

   // Derived sizes and the constant reciprocal of 58 * NUM_SAMPLES.
   localparam int PASS_W = $clog2(NUM_SAMPLES + 1);
   localparam logic [PASS_W-1:0] LAST_PASS = PASS_W'(NUM_SAMPLES - 1);
   localparam longint unsigned DIVISOR = longint'(uer_pkg::CM_DIVISOR * NUM_SAMPLES);
   localparam logic [uer_pkg::RECIP_W-1:0] RECIP =
      uer_pkg::RECIP_W'(((64'd1 << uer_pkg::RECIP_SHIFT) + DIVISOR - 64'd1) / DIVISOR);
   localparam int DIVIDEND_W = uer_pkg::SUM_W + uer_pkg::DIST_FRAC_W;
   localparam int PROD_W     = DIVIDEND_W + uer_pkg::RECIP_W;

   // Configuration registers.
   logic [uer_pkg::TRIG_W-1:0]  trig_width_ff;
   logic [uer_pkg::TIMER_W-1:0] settle_gap_ff;
   logic [uer_pkg::ECHO_W-1:0]  max_echo_ff;

   // Sequencer state.
   uer_pkg::phase_type           phase_ff, phase_in;
   logic [uer_pkg::TIMER_W-1:0]  timer_ff, timer_in;
   logic [uer_pkg::ECHO_W-1:0]   width_ff, width_in;
   logic [PASS_W-1:0]            pass_ff, pass_in;
   logic [uer_pkg::SUM_W-1:0]    sum_ff, sum_in;
   logic                         done_in;

   // Pipeline registers.
   logic                         s1_valid_ff;
   uer_pkg::flags_type           s1_flags_ff;
   logic [uer_pkg::SUM_W-1:0]    s1_sum_ff;
   logic                         s2_valid_ff;
   uer_pkg::flags_type           s2_flags_ff;
   logic [uer_pkg::DIST_W-1:0]   s2_quot_ff;
   logic                         out_valid_ff;
   uer_pkg::flags_type           out_flags_ff;
   logic [uer_pkg::DIST_W-1:0]   out_dist_ff;

   logic                         out_ready;
   logic                         s2_ready;
   logic                         s1_ready;
   logic                         req_fire;
   logic [uer_pkg::TRIG_W-1:0]   trig_eff;
   logic [uer_pkg::ECHO_W:0]     width_inc;
   logic [PROD_W-1:0]            product;

   // Per-stage ready: a stage takes a transfer when it is empty or draining.
   assign out_ready = !out_valid_ff || rsp_ch.ready;
   assign s2_ready  = !s2_valid_ff || out_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_ch.ready = s1_ready;
   assign req_fire  = req_ch.valid && s1_ready;
   assign csr_ch.ready = 1'b1;

   // Configuration writes; an index beyond the list is dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         trig_width_ff <= uer_pkg::TRIG_WIDTH_RST;
         settle_gap_ff <= uer_pkg::SETTLE_GAP_RST;
         max_echo_ff   <= uer_pkg::MAX_ECHO_RST;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            uer_pkg::CSR_TRIGGER_WIDTH: trig_width_ff <= csr_ch.data[uer_pkg::TRIG_W-1:0];
            uer_pkg::CSR_SETTLE_GAP:    settle_gap_ff <= csr_ch.data;
            uer_pkg::CSR_MAX_ECHO:      max_echo_ff   <= csr_ch.data;
            default: ;
         endcase
      end
   end

   // A trigger width of zero behaves as one tick.
   assign trig_eff  = (trig_width_ff == '0) ? uer_pkg::TRIG_W'(1) : trig_width_ff;
   assign width_inc = {1'b0, width_ff} + 17'd1;

   // Next sequencer state for the tick on the input channel.
   always_comb begin
      phase_in = phase_ff;
      timer_in = timer_ff;
      width_in = width_ff;
      pass_in  = pass_ff;
      sum_in   = sum_ff;
      done_in  = 1'b0;
      unique case (phase_ff)
         uer_pkg::PH_IDLE: begin
            if (req_ch.start_request) begin
               phase_in = uer_pkg::PH_TRIG;
               timer_in = uer_pkg::TIMER_W'(1);
               pass_in  = '0;
               sum_in   = '0;
               width_in = '0;
            end
         end
         uer_pkg::PH_TRIG: begin
            if (timer_ff >= {8'd0, trig_eff}) begin
               phase_in = uer_pkg::PH_WAIT;
               timer_in = '0;
            end else begin
               timer_in = timer_ff + uer_pkg::TIMER_W'(1);
            end
         end
         uer_pkg::PH_WAIT: begin
            if (req_ch.echo_level) begin
               phase_in = uer_pkg::PH_MEAS;
               width_in = (max_echo_ff == '0) ? '0 : uer_pkg::ECHO_W'(1);
            end
         end
         uer_pkg::PH_MEAS: begin
            if (req_ch.echo_level) begin
               // Count saturates at the echo limit.
               width_in = (width_inc > {1'b0, max_echo_ff}) ? max_echo_ff
                                                            : width_inc[uer_pkg::ECHO_W-1:0];
            end else begin
               sum_in   = sum_ff + uer_pkg::SUM_W'(width_ff);
               phase_in = uer_pkg::PH_SETTLE;
               timer_in = '0;
            end
         end
         uer_pkg::PH_SETTLE: begin
            if (timer_ff >= settle_gap_ff) begin
               if (pass_ff == LAST_PASS) begin
                  done_in  = 1'b1;
                  phase_in = uer_pkg::PH_IDLE;
                  timer_in = '0;
               end else begin
                  pass_in  = pass_ff + PASS_W'(1);
                  phase_in = uer_pkg::PH_TRIG;
                  timer_in = uer_pkg::TIMER_W'(1);
               end
            end else begin
               timer_in = timer_ff + uer_pkg::TIMER_W'(1);
            end
         end
         default: phase_in = uer_pkg::PH_IDLE;
      endcase
   end

   // Sequencer registers advance on each accepted tick.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= uer_pkg::PH_IDLE;
         timer_ff <= '0;
         width_ff <= '0;
         pass_ff  <= '0;
         sum_ff   <= '0;
      end else if (req_fire) begin
         phase_ff <= phase_in;
         timer_ff <= timer_in;
         width_ff <= width_in;
         pass_ff  <= pass_in;
         sum_ff   <= sum_in;
      end
   end

   // Stage 1: status flags of this tick and the sum for the average.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_flags_ff.trigger_level <= (phase_in == uer_pkg::PH_TRIG);
         s1_flags_ff.busy_res      <= (phase_in != uer_pkg::PH_IDLE);
         s1_flags_ff.result_valid  <= done_in;
         s1_sum_ff                 <= sum_in;
      end
   end

   // Stage 2: divide sum * 16 by 58 * NUM_SAMPLES through the reciprocal.
   assign product = PROD_W'({s1_sum_ff, uer_pkg::DIST_FRAC_W'(0)}) * PROD_W'(RECIP);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         s2_flags_ff <= s1_flags_ff;
         s2_quot_ff  <= product[uer_pkg::RECIP_SHIFT +: uer_pkg::DIST_W];
      end
   end

   // Output register: the distance is loaded on a result and held otherwise.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         out_dist_ff  <= '0;
      end else if (out_ready) begin
         out_valid_ff <= s2_valid_ff;
         if (s2_valid_ff && s2_flags_ff.result_valid) begin
            out_dist_ff <= s2_quot_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && s2_valid_ff) begin
         out_flags_ff <= s2_flags_ff;
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.trigger_level = out_flags_ff.trigger_level;
   assign rsp_ch.busy_res      = out_flags_ff.busy_res;
   assign rsp_ch.result_valid  = out_flags_ff.result_valid;
   assign rsp_ch.distance_q4   = out_dist_ff;

   // A result strobe always comes with the sequencer back in idle.
   `UER_ASSERT_NOW(a_result_idle, clock, reset, out_valid_ff && out_flags_ff.result_valid,
      !out_flags_ff.busy_res)
   // The pass counter never runs past the last pass.
   `UER_ASSERT_NOW(a_pass_range, clock, reset, 1'b1, pass_ff <= LAST_PASS)
   // An accepted tick is held in the first stage on the next cycle.
   `UER_ASSERT_NEXT(a_tick_enters, clock, reset, req_fire, s1_valid_ff)

endmodule

### tb/sv/echo_ranging_checker.sv
// Checker that mirrors the ranging sequencer and compares every result transfer.
module echo_ranging_checker #(
   parameter int NUM_SAMPLES = 5
) (
   input  logic clock,
   input  logic reset,
   input  logic run_done,
   uer_req_if   req_ch,
   uer_rsp_if   rsp_ch,
   uer_csr_if   csr_ch,
   output int   fail_count
);
   import uer_pkg::*;

   // Pin levels and distance that one accepted tick should produce.
   typedef struct packed {
      logic              trigger_level;
      logic              busy_res;
      logic              result_valid;
      logic [DIST_W-1:0] distance_q4;
   } tick_outputs_t;

   tick_outputs_t tick_outputs_due[$];

   // Register copies.
   logic [TRIG_W-1:0]  trig_width;
   logic [TIMER_W-1:0] settle_gap;
   logic [ECHO_W-1:0]  echo_limit;

   // Sequencer copy.
   phase_type          seq_phase;
   logic [TIMER_W-1:0] tick_timer;
   logic [ECHO_W-1:0]  echo_width;
   logic [2:0]         pass_index;
   logic [SUM_W-1:0]   width_sum;
   logic [DIST_W-1:0]  last_distance;
   bit                 leftover_checked;

   // Advance the sequencer copy by one microsecond tick.
   task automatic advance_ranger(input logic echo, input logic start,
                                 output tick_outputs_t outs);
      logic [TIMER_W-1:0] trig_ticks;
      logic [ECHO_W:0]    grown;
      logic [63:0]        scaled;
      logic               strobe;
      strobe = 1'b0;
      // A zero trigger width still gives a one-tick pulse.
      trig_ticks = (trig_width == '0) ? TIMER_W'(1) : TIMER_W'(trig_width);
      case (seq_phase)
         PH_IDLE: begin
            if (start) begin
               seq_phase  = PH_TRIG;
               tick_timer = TIMER_W'(1);
               pass_index = '0;
               width_sum  = '0;
               echo_width = '0;
            end
         end
         PH_TRIG: begin
            if (tick_timer >= trig_ticks) begin
               seq_phase  = PH_WAIT;
               tick_timer = '0;
            end else begin
               tick_timer = tick_timer + 1'b1;
            end
         end
         PH_WAIT: begin
            if (echo) begin
               seq_phase  = PH_MEAS;
               echo_width = (echo_limit == '0) ? '0 : ECHO_W'(1);
            end
         end
         PH_MEAS: begin
            if (echo) begin
               // The width count saturates at the echo limit.
               grown      = {1'b0, echo_width} + 1'b1;
               echo_width = (grown > {1'b0, echo_limit}) ? echo_limit : grown[ECHO_W-1:0];
            end else begin
               width_sum  = width_sum + SUM_W'(echo_width);
               seq_phase  = PH_SETTLE;
               tick_timer = '0;
            end
         end
         PH_SETTLE: begin
            if (tick_timer >= settle_gap) begin
               if (int'(pass_index) + 1 >= NUM_SAMPLES) begin
                  // Average over all passes, scaled to 4 fraction bits.
                  scaled        = 64'(width_sum) * 64'd16;
                  last_distance = DIST_W'(scaled / 64'(CM_DIVISOR * NUM_SAMPLES));
                  strobe        = 1'b1;
                  seq_phase     = PH_IDLE;
                  tick_timer    = '0;
               end else begin
                  pass_index = pass_index + 1'b1;
                  seq_phase  = PH_TRIG;
                  tick_timer = TIMER_W'(1);
               end
            end else begin
               tick_timer = tick_timer + 1'b1;
            end
         end
         default: seq_phase = PH_IDLE;
      endcase
      outs.trigger_level = (seq_phase == PH_TRIG);
      outs.busy_res      = (seq_phase != PH_IDLE);
      outs.result_valid  = strobe;
      outs.distance_q4   = last_distance;
   endtask

   // Watch all three channels at every rising edge.
   always @(posedge clock) begin : channel_watch
      tick_outputs_t expected;
      tick_outputs_t predicted;
      int            errs;
      errs = 0;
      if (reset) begin
         trig_width       = TRIG_WIDTH_RST;
         settle_gap       = SETTLE_GAP_RST;
         echo_limit       = MAX_ECHO_RST;
         seq_phase        = PH_IDLE;
         tick_timer       = '0;
         echo_width       = '0;
         pass_index       = '0;
         width_sum        = '0;
         last_distance    = '0;
         leftover_checked = 1'b0;
         tick_outputs_due.delete();
      end else begin
         // Register writes; an unused index changes nothing.
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               CSR_TRIGGER_WIDTH: trig_width = csr_ch.data[TRIG_W-1:0];
               CSR_SETTLE_GAP:    settle_gap = csr_ch.data[TIMER_W-1:0];
               CSR_MAX_ECHO:      echo_limit = csr_ch.data[ECHO_W-1:0];
               default: ;
            endcase
         end

         // Compare a result transfer against the oldest expectation.
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (tick_outputs_due.size() == 0) begin
               $error("result transfer arrived with no expected result pending");
               errs++;
            end else begin
               expected = tick_outputs_due.pop_front();
               if (rsp_ch.trigger_level !== expected.trigger_level) begin
                  $error("trigger_level: expected %0b, got %0b",
                         expected.trigger_level, rsp_ch.trigger_level);
                  errs++;
               end
               if (rsp_ch.busy_res !== expected.busy_res) begin
                  $error("busy_res: expected %0b, got %0b",
                         expected.busy_res, rsp_ch.busy_res);
                  errs++;
               end
               if (rsp_ch.result_valid !== expected.result_valid) begin
                  $error("result_valid: expected %0b, got %0b",
                         expected.result_valid, rsp_ch.result_valid);
                  errs++;
               end
               if (rsp_ch.distance_q4 !== expected.distance_q4) begin
                  $error("distance_q4: expected %0d, got %0d",
                         expected.distance_q4, rsp_ch.distance_q4);
                  errs++;
               end
            end
         end

         // Every accepted tick yields exactly one result.
         if (req_ch.valid && req_ch.ready) begin
            advance_ranger(req_ch.echo_level, req_ch.start_request, predicted);
            tick_outputs_due.push_back(predicted);
         end

         if (run_done && !leftover_checked) begin
            leftover_checked = 1'b1;
            if (tick_outputs_due.size() != 0) begin
               $error("%0d expected results never arrived", tick_outputs_due.size());
               errs++;
            end
         end
      end
      fail_count <= fail_count + errs;
   end

endmodule

### tb/sv/ultrasonic_echo_ranging_tb.sv
// Stimulus, handshake pacing and verdict for the ultrasonic echo ranging block.
module ultrasonic_echo_ranging_tb;
   import uer_pkg::*;

   localparam int NUM_SAMPLES = 5;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 2'd3;
   // Long receiver stall, started once after this many result transfers.
   localparam int HOLD_AT     = 60;
   localparam int HOLD_CYCLES = 40;
   localparam int DRAIN_CHUNK = 32;
   localparam int TAIL_CYCLES = 8;
   // Time limit for the whole run, meant to outlast the slowest correct run even
   // with both sides idling often.
   localparam int TIMEOUT     = 40_000;

   logic clock;
   logic reset;
   logic run_done;

   uer_req_if req_ch();
   uer_rsp_if rsp_ch();
   uer_csr_if csr_ch();

   int          fail_count;
   int          sent_count;
   int          got_count;
   int          distances_seen;
   int          settings_seen;
   int          sender_idle_pct;
   int          receiver_idle_pct;
   int          hold_left;
   bit          hold_done;
   logic        last_busy;
   logic [15:0] cur_trig;
   logic [15:0] cur_settle;

   ultrasonic_echo_ranging #(
      .NUM_SAMPLES(NUM_SAMPLES)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   echo_ranging_checker #(
      .NUM_SAMPLES(NUM_SAMPLES)
   ) checker_inst (
      .clock     (clock),
      .reset     (reset),
      .run_done  (run_done),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_ch    (csr_ch),
      .fail_count(fail_count)
   );

   // Clock.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #TIMEOUT;
      $display("CHECKS FAILED");
      $finish;
   end

   // Result side: random stalls, one long stall, and transfer bookkeeping.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= 0;
         last_busy    <= 1'b0;
      end else begin
         if (hold_left != 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
         end else if (!hold_done && got_count >= HOLD_AT) begin
            rsp_ch.ready <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            hold_done    <= 1'b1;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got_count <= got_count + 1;
            last_busy <= rsp_ch.busy_res;
            if (rsp_ch.result_valid)
               distances_seen <= distances_seen + 1;
         end
      end
   end

   // Flip a level with the given chance in percent.
   function automatic logic noisy(input logic level, input int pct);
      return level ^ ($urandom_range(0, 99) < pct);
   endfunction

   // Offer one tick and wait for its transfer; valid stays high afterwards.
   task automatic send_tick(input logic echo, input logic start);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.echo_level    <= echo;
      req_ch.start_request <= start;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent_count++;
   endtask

   // One register write; the caller lowers valid after the last one.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index, input logic [15:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
   endtask

   task automatic apply_settings(input logic [15:0] trig_data, input logic [15:0] settle,
                                 input logic [15:0] limit);
      write_reg(CSR_TRIGGER_WIDTH, trig_data);
      write_reg(CSR_SETTLE_GAP, settle);
      write_reg(CSR_MAX_ECHO, limit);
      csr_ch.valid <= 1'b0;
      cur_trig   = trig_data;
      cur_settle = settle;
      settings_seen++;
   endtask

   // Wait for every result, then feed echo pulses until the block is idle.
   task automatic drain_to_idle();
      int i;
      req_ch.valid <= 1'b0;
      while (got_count != sent_count) @(posedge clock);
      while (last_busy) begin
         for (i = 0; i < DRAIN_CHUNK; i++)
            send_tick(i % 8 < 3, 1'b0);
         req_ch.valid <= 1'b0;
         while (got_count != sent_count) @(posedge clock);
      end
   endtask

   // A start followed by echo shapes that fit the current settings.
   task automatic run_sequence(input int max_high, input int noise_pct);
      int tw_eff;
      int p;
      int i;
      int ticks;
      tw_eff = (cur_trig[TRIG_W-1:0] == '0) ? 1 : int'(cur_trig[TRIG_W-1:0]);
      send_tick(1'($urandom_range(0, 1)), 1'b1);
      for (p = 0; p < NUM_SAMPLES; p++) begin
         // Echo is ignored while the trigger pulse runs.
         for (i = 0; i < tw_eff; i++)
            send_tick(1'($urandom_range(0, 1)), noisy(1'b0, noise_pct));
         ticks = $urandom_range(0, 3);
         for (i = 0; i < ticks; i++)
            send_tick(noisy(1'b0, noise_pct), noisy(1'b0, noise_pct));
         ticks = $urandom_range(1, max_high);
         for (i = 0; i < ticks; i++)
            send_tick(noisy(1'b1, noise_pct), noisy(1'b0, noise_pct));
         // Falling edge, the settle gap, and the tick that ends the gap.
         ticks = int'(cur_settle) + 2;
         for (i = 0; i < ticks; i++)
            send_tick(noisy(1'b0, noise_pct), noisy(1'b0, noise_pct));
      end
   endtask

   task automatic run_phase(input logic [15:0] trig_data, input logic [15:0] settle,
                            input logic [15:0] limit, input int sequences,
                            input int max_high, input int noise_pct);
      int s;
      int i;
      int junk;
      apply_settings(trig_data, settle, limit);
      for (s = 0; s < sequences; s++) begin
         // Loose ticks between sequences, now and then with a stray start.
         junk = (noise_pct > 0) ? $urandom_range(0, 6) : 0;
         for (i = 0; i < junk; i++)
            send_tick(1'($urandom_range(0, 1)), noisy(1'b0, 10));
         run_sequence(max_high, noise_pct);
      end
      drain_to_idle();
   endtask

   // Main stimulus.
   initial begin
      int p;
      reset                <= 1'b1;
      run_done             <= 1'b0;
      req_ch.valid         <= 1'b0;
      req_ch.echo_level    <= 1'b0;
      req_ch.start_request <= 1'b0;
      csr_ch.valid         <= 1'b0;
      csr_ch.index         <= CSR_TRIGGER_WIDTH;
      csr_ch.data          <= '0;
      sender_idle_pct   = 7;
      receiver_idle_pct = 47;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: zero trigger width, zero settle gap, zero echo limit, and a
      // write to the unused register index.
      write_reg(CSR_TRIGGER_WIDTH, 16'd0);
      write_reg(CSR_SETTLE_GAP, 16'd0);
      write_reg(CSR_MAX_ECHO, 16'd0);
      write_reg(CSR_UNUSED_INDEX, 16'hFFFF);
      csr_ch.valid <= 1'b0;
      settings_seen++;
      // Echo while idle is ignored, then a start.
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b1);
      for (p = 0; p < NUM_SAMPLES; p++) begin
         // Start while busy is ignored; every echo count stays zero.
         send_tick(1'b1, 1'b1);
         send_tick(1'b1, 1'b0);
         send_tick(1'b1, 1'b0);
         send_tick(1'b0, 1'b0);
         send_tick(1'b0, 1'b1);
      end
      drain_to_idle();

      // Sender rarely idles, receiver often stalls.
      run_phase(16'd1, 16'd0, 16'd1, 3, 4, 5);
      run_phase(16'($urandom_range(1, 6)), 16'($urandom_range(0, 8)),
                16'($urandom_range(1, 30)), 1, 20, 5);

      // Sender often idles, receiver rarely stalls; a longer trigger with the
      // upper data byte set, and the largest echo limit.
      sender_idle_pct   = 47;
      receiver_idle_pct = 7;
      run_phase(16'h5A10, 16'd0, 16'hFFFF, 1, 24, 3);
      run_phase(16'($urandom_range(1, 6)), 16'($urandom_range(0, 8)),
                16'($urandom_range(1, 30)), 1, 20, 5);

      // No idling on either side; finally a longer settle gap.
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      run_phase(16'($urandom_range(1, 6)), 16'($urandom_range(0, 8)),
                16'($urandom_range(1, 30)), 1, 20, 5);
      run_phase(16'd2, 16'd16, 16'd7, 1, 12, 0);

      repeat (TAIL_CYCLES) @(posedge clock);
      run_done <= 1'b1;
      repeat (2) @(posedge clock);

      $display("Run covered %0d ticks, %0d averaged distances, %0d register settings.",
               sent_count, distances_seen, settings_seen);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

### ultrasonic_echo_ranging.f
+incdir+hdl
hdl/uer_pkg.sv
hdl/uer_req_if.sv
hdl/ultrasonic_echo_ranging.sv
tb/sv/echo_ranging_checker.sv
tb/sv/ultrasonic_echo_ranging_tb.sv
